@@ rtl/hus_pkg.sv @@
`timescale 1ns / 1ps

package hus_pkg;

  localparam int MAX_HOST_DEF  = 512;
  localparam int MAX_INPUT_DEF = 4096;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;
  localparam logic [16:0] PORT_MAX   = 17'd65535;
  localparam logic [16:0] PORT_SAT   = 17'd65536;

  localparam logic [3:0] LEN_HTTP  = 4'd7;
  localparam logic [3:0] LEN_HTTPS = 4'd8;
  localparam logic [3:0] SCHEME_LEN_HTTP  = 4'd4;
  localparam logic [3:0] SCHEME_LEN_HTTPS = 4'd5;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 64;

  typedef enum logic [4:0] {
    PH_PREFIX = 5'b00001,
    PH_HOST   = 5'b00010,
    PH_PORT   = 5'b00100,
    PH_PATH   = 5'b01000,
    PH_SKIP   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        url_valid;
    logic        is_https;
    logic [15:0] port_number;
    logic [11:0] host_offset;
    logic [8:0]  host_length;
    logic        path_given;
    logic [11:0] path_offset;
    logic [8:0]  path_length;
  } result_t;

  // expected prefix character at index idx
  function automatic logic [7:0] pfx_char(input logic [3:0] idx, input logic secure);
    logic [7:0] c;
    begin
      case (idx)
        4'd0:    c = 8'h68;
        4'd1:    c = 8'h74;
        4'd2:    c = 8'h74;
        4'd3:    c = 8'h70;
        4'd4:    c = secure ? CH_S : CH_COLON;
        4'd5:    c = secure ? CH_COLON : CH_SLASH;
        4'd6:    c = CH_SLASH;
        4'd7:    c = secure ? CH_SLASH : CH_NUL;
        default: c = CH_NUL;
      endcase
      return c;
    end
  endfunction

  function automatic logic [TDATA_OUT_W-1:0] pack_result(input result_t r);
    logic [TDATA_OUT_W-1:0] d;
    begin
      d = '0;
      d[0]     = r.url_valid;
      d[1]     = r.is_https;
      d[17:2]  = r.port_number;
      d[29:18] = r.host_offset;
      d[38:30] = r.host_length;
      d[39]    = r.path_given;
      d[51:40] = r.path_offset;
      d[60:52] = r.path_length;
      return d;
    end
  endfunction

endpackage

@@ rtl/hus_in_reg.sv @@
`timescale 1ns / 1ps

module hus_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] byte_val
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_tready = !vld_r || take;
  assign vld_nxt   = (in_tvalid && in_tready) || (vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
    end
  end

  assign byte_vld = vld_r;
  assign byte_val = byte_r;

endmodule

@@ rtl/hus_core.sv @@
`timescale 1ns / 1ps

module hus_core #(
  parameter int MAX_HOST  = hus_pkg::MAX_HOST_DEF,
  parameter int MAX_INPUT = hus_pkg::MAX_INPUT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_vld,
  input  logic [7:0]        byte_val,
  input  logic              res_ready,
  output logic              byte_take,
  output logic              res_vld,
  output hus_pkg::result_t  res
);

  localparam int HCW = $clog2(MAX_HOST + 1);
  localparam int PCW = $clog2(MAX_HOST);
  localparam int BPW = $clog2(MAX_INPUT + 2);

  hus_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0]       pfx_cnt_r, pfx_cnt_nxt;
  logic             https_r, https_nxt;
  logic [BPW-1:0]   pos_r, pos_nxt;
  logic [3:0]       host_start_r, host_start_nxt;
  logic [HCW-1:0]   host_cnt_r, host_cnt_nxt;
  logic [16:0]      port_acc_r, port_acc_nxt;
  logic             port_pres_r, port_pres_nxt;
  logic [11:0]      path_start_r, path_start_nxt;
  logic [PCW-1:0]   path_cnt_r, path_cnt_nxt;
  logic             err_r, err_nxt;

  // state seen by the body logic (prefix bytes replayed as host when in prefix phase)
  hus_pkg::phase_t  e_phase;
  logic             e_https;
  logic [3:0]       e_host_start;
  logic [HCW-1:0]   e_host_cnt;
  logic [16:0]      e_port_acc;
  logic             e_port_pres;
  logic [11:0]      e_path_start;
  logic [PCW-1:0]   e_path_cnt;
  logic             e_err;

  logic [3:0]       rp_host;
  logic             is_term;
  logic             pfx_s_hit;
  logic             pfx_hit;
  logic [3:0]       pfx_inc;
  logic [19:0]      port_mul;
  logic             is_digit;
  logic             host_bad;
  logic             port_bad;
  logic             f_err;
  logic             f_valid;

  assign is_term   = (byte_val == hus_pkg::CH_NUL);
  assign byte_take = byte_vld && (!is_term || res_ready);
  assign is_digit  = (byte_val >= hus_pkg::CH_D0) && (byte_val <= hus_pkg::CH_D9);
  assign pfx_s_hit = (pfx_cnt_r == hus_pkg::SCHEME_LEN_HTTP) && !https_r &&
                     (byte_val == hus_pkg::CH_S);
  assign pfx_hit   = (byte_val == hus_pkg::pfx_char(pfx_cnt_r, https_r));
  assign pfx_inc   = pfx_cnt_r + 4'd1;

  always_comb begin
    rp_host      = https_r ? hus_pkg::SCHEME_LEN_HTTPS : hus_pkg::SCHEME_LEN_HTTP;
    if (pfx_cnt_r < rp_host) begin
      rp_host = pfx_cnt_r;
    end
    e_phase      = phase_r;
    e_https      = https_r;
    e_host_start = host_start_r;
    e_host_cnt   = host_cnt_r;
    e_port_acc   = port_acc_r;
    e_port_pres  = port_pres_r;
    e_path_start = path_start_r;
    e_path_cnt   = path_cnt_r;
    e_err        = err_r;
    if (phase_r == hus_pkg::PH_PREFIX) begin
      e_phase      = hus_pkg::PH_HOST;
      e_https      = 1'b0;
      e_host_start = 4'd0;
      e_host_cnt   = HCW'(rp_host);
      if (pfx_cnt_r > rp_host) begin
        e_phase     = hus_pkg::PH_PORT;
        e_port_pres = 1'b1;
        e_port_acc  = '0;
      end
      if (pfx_cnt_r > rp_host + 4'd1) begin
        e_phase      = hus_pkg::PH_PATH;
        e_err        = 1'b1;
        e_path_start = 12'(rp_host + 4'd1);
        e_path_cnt   = PCW'(1);
      end
    end
  end

  assign host_bad = (e_host_cnt == '0) || (e_host_cnt >= HCW'(MAX_HOST));
  assign port_bad = (e_port_acc == '0) || (e_port_acc > hus_pkg::PORT_MAX);
  assign port_mul = {e_port_acc, 3'b000} + {2'b00, e_port_acc, 1'b0} +
                    {16'd0, byte_val[3:0]};

  always_comb begin
    phase_nxt      = e_phase;
    pfx_cnt_nxt    = pfx_cnt_r;
    https_nxt      = e_https;
    host_start_nxt = e_host_start;
    host_cnt_nxt   = e_host_cnt;
    port_acc_nxt   = e_port_acc;
    port_pres_nxt  = e_port_pres;
    path_start_nxt = e_path_start;
    path_cnt_nxt   = e_path_cnt;
    err_nxt        = e_err;
    pos_nxt        = pos_r;
    if (pos_r <= BPW'(MAX_INPUT)) begin
      pos_nxt = pos_r + BPW'(1);
    end
    if ((phase_r == hus_pkg::PH_PREFIX) && (pfx_s_hit || pfx_hit)) begin
      phase_nxt      = phase_r;
      https_nxt      = https_r;
      host_start_nxt = host_start_r;
      host_cnt_nxt   = host_cnt_r;
      port_acc_nxt   = port_acc_r;
      port_pres_nxt  = port_pres_r;
      path_start_nxt = path_start_r;
      path_cnt_nxt   = path_cnt_r;
      err_nxt        = err_r;
      pfx_cnt_nxt    = pfx_inc;
      if (pfx_s_hit) begin
        https_nxt = 1'b1;
      end else if (pfx_inc == (https_r ? hus_pkg::LEN_HTTPS : hus_pkg::LEN_HTTP)) begin
        phase_nxt      = hus_pkg::PH_HOST;
        host_start_nxt = pfx_inc;
        host_cnt_nxt   = '0;
      end
    end else begin
      unique case (e_phase)
        hus_pkg::PH_HOST: begin
          if (byte_val == hus_pkg::CH_COLON) begin
            err_nxt       = e_err | host_bad;
            port_pres_nxt = 1'b1;
            port_acc_nxt  = '0;
            phase_nxt     = hus_pkg::PH_PORT;
          end else if (byte_val == hus_pkg::CH_SLASH) begin
            err_nxt        = e_err | host_bad;
            phase_nxt      = hus_pkg::PH_PATH;
            path_start_nxt = 12'(pos_r);
            path_cnt_nxt   = PCW'(1);
          end else if (e_host_cnt < HCW'(MAX_HOST)) begin
            host_cnt_nxt = e_host_cnt + HCW'(1);
          end
        end
        hus_pkg::PH_PORT: begin
          if (is_digit) begin
            port_acc_nxt = (port_mul > 20'(hus_pkg::PORT_MAX)) ? hus_pkg::PORT_SAT
                                                                : port_mul[16:0];
          end else begin
            err_nxt = e_err | port_bad;
            if (byte_val == hus_pkg::CH_SLASH) begin
              phase_nxt      = hus_pkg::PH_PATH;
              path_start_nxt = 12'(pos_r);
              path_cnt_nxt   = PCW'(1);
            end else begin
              phase_nxt = hus_pkg::PH_SKIP;
            end
          end
        end
        hus_pkg::PH_PATH: begin
          if (e_path_cnt < PCW'(MAX_HOST - 1)) begin
            path_cnt_nxt = e_path_cnt + PCW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    f_err = e_err;
    if (e_phase == hus_pkg::PH_HOST) begin
      f_err = e_err | host_bad;
    end else if (e_phase == hus_pkg::PH_PORT) begin
      f_err = e_err | port_bad;
    end
    f_valid = !f_err && (pos_r <= BPW'(MAX_INPUT));
    res = '0;
    if (f_valid) begin
      res.url_valid   = 1'b1;
      res.is_https    = e_https;
      res.port_number = e_port_pres ? e_port_acc[15:0]
                                    : (e_https ? hus_pkg::PORT_HTTPS : hus_pkg::PORT_HTTP);
      res.host_offset = 12'(e_host_start);
      res.host_length = 9'(e_host_cnt);
      if (e_phase == hus_pkg::PH_PATH) begin
        res.path_given  = 1'b1;
        res.path_offset = e_path_start;
        res.path_length = 9'(e_path_cnt);
      end
    end
  end

  assign res_vld = byte_take && is_term;

  always_ff @(posedge clk) begin
    if (!rst_n || res_vld) begin
      phase_r      <= hus_pkg::PH_PREFIX;
      pfx_cnt_r    <= '0;
      https_r      <= 1'b0;
      pos_r        <= '0;
      host_start_r <= '0;
      host_cnt_r   <= '0;
      port_acc_r   <= '0;
      port_pres_r  <= 1'b0;
      path_start_r <= '0;
      path_cnt_r   <= '0;
      err_r        <= 1'b0;
    end else if (byte_take) begin
      phase_r      <= phase_nxt;
      pfx_cnt_r    <= pfx_cnt_nxt;
      https_r      <= https_nxt;
      pos_r        <= pos_nxt;
      host_start_r <= host_start_nxt;
      host_cnt_r   <= host_cnt_nxt;
      port_acc_r   <= port_acc_nxt;
      port_pres_r  <= port_pres_nxt;
      path_start_r <= path_start_nxt;
      path_cnt_r   <= path_cnt_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

@@ rtl/hus_out_reg.sv @@
`timescale 1ns / 1ps

module hus_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                res_vld,
  input  hus_pkg::result_t                    res,
  output logic                                res_ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [hus_pkg::TDATA_OUT_W-1:0]     out_tdata
);

  logic                              vld_r;
  logic                              vld_nxt;
  logic [hus_pkg::TDATA_OUT_W-1:0]   data_r;

  assign res_ready = !vld_r || out_tready;
  assign vld_nxt   = res_vld || (vld_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      data_r <= hus_pkg::pack_result(res);
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule

@@ rtl/http_url_splitter.sv @@
`timescale 1ns / 1ps

// channel | dir | ports                         | item
// in_     | in  | in_tvalid/in_tready/in_tdata  | one URL byte, zero ends the URL
// out_    | out | out_tvalid/out_tready/out_tdata | one parsed URL per zero byte
//
// One byte per cycle sustained unless a stalled out_ holds a terminator: input register, parse update, result register.
// A terminator passes the input register, then the result register, which drives out_tvalid.
// rst_n (synchronous) clears the parser state and the valid flags of both registers.
// A stalled out_ holds the next terminator in the input register; in_ stalls behind it.

module http_url_splitter #(
  parameter int MAX_HOST  = hus_pkg::MAX_HOST_DEF,
  parameter int MAX_INPUT = hus_pkg::MAX_INPUT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hus_pkg::TDATA_IN_W-1:0]   in_tdata,   // [7:0] url_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] url_valid, [1] is_https, [17:2] port_number, [29:18] host_offset,
  // [38:30] host_length, [39] path_given, [51:40] path_offset, [60:52] path_length
  output logic [hus_pkg::TDATA_OUT_W-1:0]  out_tdata
);

  logic             byte_vld;
  logic [7:0]       byte_val;
  logic             byte_take;
  logic             res_vld;
  logic             res_ready;
  hus_pkg::result_t res;

  hus_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .take      (byte_take),
    .byte_vld  (byte_vld),
    .byte_val  (byte_val)
  );

  hus_core #(
    .MAX_HOST  (MAX_HOST),
    .MAX_INPUT (MAX_INPUT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .byte_val  (byte_val),
    .res_ready (res_ready),
    .byte_take (byte_take),
    .res_vld   (res_vld),
    .res       (res)
  );

  hus_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
